// ===== rtl/core/sse_pkg.sv =====
// Shared types and constants for the sorted set engine.
// Used by the controller, the datapath and the top level; no dependencies.
package sse_pkg;

  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int IDX_W = 6;
  localparam int ST_W  = 3;
  localparam int CNT_W = 7;
  localparam int SUM_W = 38;

  // read path: 2**IDX_W positions, split into groups for a two-level select
  localparam int READ_SPAN = 64;
  localparam int GRP_W     = 3;
  localparam int GRP_N     = 8;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP    = 3'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // input transfer: latch the item and the cell flags
    logic apply;  // shift the cells and load the output register
  } ctrl_t;

endpackage

// ===== rtl/core/sse_ctrl.sv =====
// Controller of the sorted set engine: sequences accept and update steps
// and owns the output valid flag. Depends on sse_pkg.
module sse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sse_pkg::ctrl_t ctrl
);

  sse_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sse_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctrl.load  = 1'b0;
    ctrl.apply = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      sse_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = sse_pkg::S_UPD;
        end
      end
      sse_pkg::S_UPD: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          ctrl.apply = 1'b1;
          state_nxt  = sse_pkg::S_IDLE;
        end
      end
      default: state_nxt = sse_pkg::S_IDLE;
    endcase
    out_valid_nxt = ctrl.apply | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/sse_datapath.sv =====
// Datapath of the sorted set engine: the row of compare-and-shift cells,
// fill count, running sum, read select and output register. Depends on sse_pkg.
module sse_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sse_pkg::ctrl_t                    ctrl,
  input  logic        [sse_pkg::CMD_W-1:0]  in_cmd,
  input  logic signed [sse_pkg::VAL_W-1:0]  in_value,
  input  logic        [sse_pkg::IDX_W-1:0]  in_index,
  output logic        [sse_pkg::ST_W-1:0]   out_status,
  output logic        [sse_pkg::CNT_W-1:0]  out_count,
  output logic signed [sse_pkg::SUM_W-1:0]  out_total,
  output logic signed [sse_pkg::VAL_W-1:0]  out_item
);

  localparam int FILL_W = $clog2(CAPACITY + 1);

  logic signed [sse_pkg::VAL_W-1:0] cell_r [CAPACITY];
  logic        [CAPACITY-1:0]       lt_r, eq_r;
  logic        [CAPACITY-1:0]       lt_nxt, eq_nxt;
  logic        [FILL_W-1:0]         fill_r, fill_nxt;
  logic signed [sse_pkg::SUM_W-1:0] sum_r, sum_nxt;

  logic        [sse_pkg::CMD_W-1:0] cmd_r;
  logic signed [sse_pkg::VAL_W-1:0] value_r;
  logic        [sse_pkg::IDX_W-1:0] index_r;

  logic signed [sse_pkg::VAL_W-1:0] rd_entry [sse_pkg::READ_SPAN];
  logic signed [sse_pkg::VAL_W-1:0] grp_r [sse_pkg::GRP_N];

  logic        [sse_pkg::ST_W-1:0]  status_nxt;
  logic signed [sse_pkg::VAL_W-1:0] item_nxt;
  logic                             found, full, in_range, add_do, del_do;

  // per-cell compare against the incoming value, registered on transfer
  for (genvar i = 0; i < CAPACITY; i++) begin : g_flag
    logic held;
    assign held      = FILL_W'(i) < fill_r;
    assign lt_nxt[i] = held && (cell_r[i] < in_value);
    assign eq_nxt[i] = held && (cell_r[i] == in_value);
  end

  for (genvar j = 0; j < sse_pkg::READ_SPAN; j++) begin : g_rd
    if (j < CAPACITY) begin : g_cell
      assign rd_entry[j] = cell_r[j];
    end else begin : g_pad
      assign rd_entry[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      index_r <= in_index;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
      for (int g = 0; g < sse_pkg::GRP_N; g++) begin
        grp_r[g] <= rd_entry[{g[sse_pkg::GRP_W-1:0], in_index[sse_pkg::GRP_W-1:0]}];
      end
    end
  end

  assign found    = |eq_r;
  assign full     = fill_r >= FILL_W'(CAPACITY);
  assign in_range = (32'(index_r) < 32'(fill_r)) && (32'(index_r) < 32'(CAPACITY));
  assign add_do   = (cmd_r == sse_pkg::CMD_ADD) && !found && !full;
  assign del_do   = (cmd_r == sse_pkg::CMD_DEL) && found;

  always_comb begin
    status_nxt = sse_pkg::ST_OK;
    item_nxt   = '0;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    case (cmd_r)
      sse_pkg::CMD_ADD: begin
        if (found) begin
          status_nxt = sse_pkg::ST_DUP;
        end else if (full) begin
          status_nxt = sse_pkg::ST_FULL;
        end else begin
          fill_nxt = fill_r + FILL_W'(1);
          sum_nxt  = sum_r + sse_pkg::SUM_W'(value_r);
        end
      end
      sse_pkg::CMD_DEL: begin
        if (found) begin
          fill_nxt = fill_r - FILL_W'(1);
          sum_nxt  = sum_r - sse_pkg::SUM_W'(value_r);
        end else begin
          status_nxt = sse_pkg::ST_ABSENT;
        end
      end
      sse_pkg::CMD_CLEAR: begin
        fill_nxt = '0;
        sum_nxt  = '0;
      end
      default: begin
        if (in_range) begin
          item_nxt = grp_r[index_r[sse_pkg::IDX_W-1:sse_pkg::GRP_W]];
        end else begin
          status_nxt = sse_pkg::ST_RANGE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else if (ctrl.apply) begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      out_status <= status_nxt;
      out_count  <= sse_pkg::CNT_W'(fill_nxt);
      out_total  <= sum_nxt;
      out_item   <= item_nxt;
    end
  end

  // cells below the insert or delete point hold; the rest take a neighbor, or the new value at the insert point
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sse_pkg::VAL_W-1:0] ins_val, del_val;
    if (i == 0) begin : g_first
      assign ins_val = value_r;
    end else begin : g_mid
      assign ins_val = lt_r[i-1] ? value_r : cell_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign del_val = cell_r[i];
    end else begin : g_next
      assign del_val = cell_r[i+1];
    end
    always_ff @(posedge clk) begin
      if (ctrl.apply && !lt_r[i]) begin
        if (add_do) begin
          cell_r[i] <= ins_val;
        end else if (del_do) begin
          cell_r[i] <= del_val;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sorted_set_engine_unit.sv =====
// Sorted set engine, top level: a controller and a cell-row datapath.
// Depends on sse_pkg, sse_ctrl and sse_datapath.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order and
// answers each add, delete, clear or read with one result carrying status,
// count, running sum and the element read. A new item is taken only once the
// last update is done. On transfer every cell compares itself against the
// value in parallel and the flags are registered; in the update step the
// cells shift one place and the output register loads. The update waits
// only while a previous result is still held by a stalled output. The set
// is empty after reset; no clearing pass is needed.
module sorted_set_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [sse_pkg::CMD_W-1:0]  in_cmd,
  input  logic signed [sse_pkg::VAL_W-1:0]  in_value,
  input  logic        [sse_pkg::IDX_W-1:0]  in_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [sse_pkg::ST_W-1:0]   out_status,
  output logic        [sse_pkg::CNT_W-1:0]  out_count,
  output logic signed [sse_pkg::SUM_W-1:0]  out_total,
  output logic signed [sse_pkg::VAL_W-1:0]  out_item
);

  sse_pkg::ctrl_t ctrl;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ctrl     (ctrl)
  );

  sse_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_cmd    (in_cmd),
    .in_value  (in_value),
    .in_index  (in_index),
    .out_status(out_status),
    .out_count (out_count),
    .out_total (out_total),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_apply_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.apply |=> out_valid)
    else $error("update did not present a result");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> in_stall)
    else $error("input taken while an item is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !ctrl.apply)
    else $error("stalled result overwritten");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sse_pkg::ST_RANGE) |-> (out_item == '0))
    else $error("failed read returned a nonzero element");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CAPACITY > 127) || (32'(out_count) <= 32'(CAPACITY))))
    else $error("count above capacity");
`endif

endmodule
